// ===== hdl/galois_field_arithmetic_unit_top_macros.svh =====
// Assertion macros for the GF(2^m) arithmetic unit.
// Included by the top level; sampled on clk_i and disabled while rst_ni is low.
`ifndef GALOIS_FIELD_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define GALOIS_FIELD_ARITHMETIC_UNIT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define GFAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gfau assertion failed");

// Next-cycle implication.
`define GFAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gfau assertion failed");

`else

`define GFAU_ASSERT_IMP(lbl, ante, cons)
`define GFAU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/gfau_pkg.sv =====
// Shared types and constants of the GF(2^m) arithmetic unit.
// No dependencies; used by gfau_step and the top level.
package gfau_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned OPND_W = 8;
  localparam int unsigned POLY_W = 9;
  localparam int unsigned RES_W  = 8;

  // Default modular polynomial x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INV = 3'd4
  } gfau_op_e;

  // Control of the shared step unit for one step.
  typedef struct packed {
    logic acc_add;    // accumulate the shifted multiplicand
    logic acc_shift;  // multiply the accumulator lane by alpha instead
  } gfau_step_ctl_t;

endpackage

// ===== hdl/gfau_step.sv =====
// Shared shift-and-add step unit for GF(2^m): one multiply step or one alpha step.
// Depends on gfau_pkg for the step control struct.
module gfau_step #(
  parameter int unsigned M = 8
) (
  input  gfau_pkg::gfau_step_ctl_t ctl_i,
  input  logic [M-1:0]             poly_i,
  input  logic [M-1:0]             acc_i,
  input  logic [M-1:0]             sh_i,
  output logic [M-1:0]             acc_o,
  output logic [M-1:0]             sh_o
);
  import gfau_pkg::*;

  // Multiply by alpha, reducing by the low bits of the polynomial on overflow.
  function automatic logic [M-1:0] xtime(input logic [M-1:0] v, input logic [M-1:0] p);
    logic [M-1:0] s;
    s = M'({v, 1'b0});
    return v[M-1] ? (s ^ p) : s;
  endfunction

  logic [M-1:0] acc_xt;
  logic [M-1:0] sh_xt;

  assign acc_xt = xtime(acc_i, poly_i);
  assign sh_xt  = xtime(sh_i, poly_i);

  // The shift lane always advances; the accumulator lane adds, advances or holds.
  assign sh_o  = sh_xt;
  assign acc_o = ctl_i.acc_shift ? acc_xt :
                 ctl_i.acc_add   ? (acc_i ^ sh_i) : acc_i;

endmodule

// ===== hdl/galois_field_arithmetic_unit_top.sv =====
// GF(2^m) arithmetic unit: add, subtract, multiply, divide and inverse.
// Depends on gfau_pkg, gfau_step and the assertion macro header.
//
//  channel   dir  fields                                   handshake
//  s_axis    in   tuser: opcode; tdata: operand_a, _b      tvalid/tready
//  m_axis    out  tdata: result; tuser: error              tvalid/tready
//  cfg       in   field_polynomial                         cfg_we_i
//
// Add and subtract go straight to the done state, and multiply takes one step per
// multiplier bit. Inverse runs the power search; divide runs it on operand_b and
// then multiplies. The exponent found by the search is at most 2^FIELD_BITS - 1.
// A search that finds nothing tries all 2^FIELD_BITS powers for either operation.
// The search steps one power per cycle through the shared step unit, which also
// runs the multiply.
// The input is not ready while an item is in work; a finished result waits until the
// output register is free, and the next item is taken once it has moved there.
// Reset loads the default polynomial and empties the output register.
`include "galois_field_arithmetic_unit_top_macros.svh"

module galois_field_arithmetic_unit_top #(
  parameter int unsigned FIELD_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfau_pkg::POLY_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [7:0] operand_a, [15:8] operand_b
  input  logic [gfau_pkg::OP_W-1:0]   s_axis_tuser,  // [2:0] opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gfau_pkg::RES_W-1:0]  m_axis_tdata,  // [7:0] result
  output logic                        m_axis_tuser   // [0] error
);
  import gfau_pkg::*;

  localparam int unsigned M  = FIELD_BITS;
  localparam int unsigned EW = (M > OPND_W) ? M : OPND_W;
  localparam int unsigned PW = (M > POLY_W) ? M : POLY_W;
  localparam bit ALPHA_OK    = (M > 1);
  localparam logic [M-1:0] ONE      = M'(1);
  localparam logic [M-1:0] MUL_LAST = M'(M - 1);
  localparam logic [M-1:0] CNT_LAST = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEARCH,
    ST_DONE
  } state_e;

  state_e         state_q, state_d;
  gfau_op_e       op_q, op_d;
  logic [M-1:0]   acc_q, acc_d;
  logic [M-1:0]   sh_q, sh_d;
  logic [M-1:0]   mul_q, mul_d;
  logic [M-1:0]   cnt_q, cnt_d;
  logic [M-1:0]   a_q, a_d;
  logic           err_q, err_d;
  logic [POLY_W-1:0] poly_q, poly_d;
  logic           out_valid_q, out_valid_d;
  logic [M-1:0]   out_res_q, out_res_d;
  logic           out_err_q, out_err_d;

  logic [EW-1:0]  a_w, b_w, res_w;
  logic [PW-1:0]  poly_w;
  logic [M-1:0]   in_a, in_b, poly_m;
  gfau_op_e       in_op;
  logic           in_fire;
  gfau_step_ctl_t step_ctl;
  logic [M-1:0]   acc_step, sh_step;

  // Operands and polynomial cut or widened to the element width.
  assign a_w    = EW'(s_axis_tdata[7:0]);
  assign b_w    = EW'(s_axis_tdata[15:8]);
  assign in_a   = a_w[M-1:0];
  assign in_b   = b_w[M-1:0];
  assign in_op  = gfau_op_e'(s_axis_tuser);
  assign poly_w = PW'(poly_q);
  assign poly_m = poly_w[M-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  gfau_step #(.M(M)) u_step (
    .ctl_i  (step_ctl),
    .poly_i (poly_m),
    .acc_i  (acc_q),
    .sh_i   (sh_q),
    .acc_o  (acc_step),
    .sh_o   (sh_step)
  );

  // Sequencer: multiply steps over the multiplier bits, the inverse search steps
  // r and p = r * x by alpha together until p is one or all powers are tried.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    acc_d       = acc_q;
    sh_d        = sh_q;
    mul_d       = mul_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    err_d       = err_q;
    poly_d      = cfg_we_i ? cfg_wdata_i : poly_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_res_d   = out_res_q;
    out_err_d   = out_err_q;
    step_ctl    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = in_op;
          a_d   = in_a;
          err_d = 1'b0;
          cnt_d = '0;
          case (in_op) inside
            OP_ADD, OP_SUB: begin
              acc_d   = in_a ^ in_b;
              state_d = ST_DONE;
            end
            OP_MUL: begin
              acc_d   = '0;
              sh_d    = in_a;
              mul_d   = in_b;
              state_d = ST_MUL;
            end
            OP_DIV: begin
              sh_d    = ONE;
              acc_d   = in_b;
              state_d = ST_SEARCH;
            end
            OP_INV: begin
              sh_d    = ONE;
              acc_d   = in_a;
              state_d = ST_SEARCH;
            end
            default: begin
              acc_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_MUL: begin
        step_ctl.acc_add = mul_q[0];
        acc_d = acc_step;
        sh_d  = sh_step;
        mul_d = mul_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_DONE;
        end
      end

      ST_SEARCH: begin
        if (acc_q == ONE) begin
          // Inverse found in sh_q.
          if (op_q == OP_DIV) begin
            acc_d   = '0;
            sh_d    = a_q;
            mul_d   = sh_q;
            cnt_d   = '0;
            state_d = ST_MUL;
          end else begin
            acc_d   = sh_q;
            state_d = ST_DONE;
          end
        end else if (cnt_q == CNT_LAST) begin
          // No power of alpha inverts the element.
          acc_d   = '0;
          err_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          step_ctl.acc_shift = 1'b1;
          acc_d = ALPHA_OK ? acc_step : '0;
          sh_d  = ALPHA_OK ? sh_step : '0;
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, working registers, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ADD;
      acc_q       <= '0;
      sh_q        <= '0;
      mul_q       <= '0;
      cnt_q       <= '0;
      a_q         <= '0;
      err_q       <= 1'b0;
      poly_q      <= POLY_RESET;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      acc_q       <= acc_d;
      sh_q        <= sh_d;
      mul_q       <= mul_d;
      cnt_q       <= cnt_d;
      a_q         <= a_d;
      err_q       <= err_d;
      poly_q      <= poly_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_err_q   <= out_err_d;
    end
  end

  assign res_w         = EW'(out_res_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_w[RES_W-1:0];
  assign m_axis_tuser  = out_err_q;

  // A failed inversion always delivers a zero element.
  `GFAU_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  // Add and subtract finish in the cycle after the request.
  `GFAU_ASSERT_NXT(a_add_fast, in_fire && (in_op == OP_ADD || in_op == OP_SUB),
                   state_q == ST_DONE)
  // The power search advances one exponent per cycle.
  `GFAU_ASSERT_IMP(a_search_step, state_q == ST_SEARCH && $past(state_q) == ST_SEARCH,
                   cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ===== test/gfau_result_checker.sv =====
// Result checker for the GF(2^m) arithmetic unit: watches the request, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on gfau_pkg for widths, opcodes and the reset polynomial.
module gfau_result_checker
  import gfau_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [POLY_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [7:0] operand_a, [15:8] operand_b
  input  logic [OP_W-1:0]   s_axis_tuser,   // [2:0] opcode
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [RES_W-1:0]  m_axis_tdata,   // [7:0] result
  input  logic              m_axis_tuser,   // [0] error
  output int                fail_count_o,
  output int                pending_count_o,
  output int                checked_count_o,
  output int                flagged_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  // One predicted result, together with the request that caused it.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    logic [RES_W-1:0] res;
    logic             err;
  } gf_expect_t;

  gf_expect_t        expected_results[$];
  logic [POLY_W-1:0] field_poly;

  // Shift-and-add product; the shifted multiplicand is reduced whenever it
  // overflows the element width and is then kept to the element width.
  function automatic logic [RES_W-1:0] gf_product(input logic [RES_W-1:0] x,
                                                  input logic [RES_W-1:0] y,
                                                  input logic [POLY_W-1:0] poly);
    logic [RES_W:0]   sh;
    logic [RES_W-1:0] mul;
    logic [RES_W-1:0] acc;
    sh  = {1'b0, x};
    mul = y;
    acc = '0;
    for (int i = 0; i < RES_W && mul != '0; i++) begin
      if (mul[0]) begin
        acc ^= sh[RES_W-1:0];
      end
      mul >>= 1;
      sh <<= 1;
      if (sh[RES_W]) begin
        sh ^= poly;
      end
      sh[RES_W] = 1'b0;
    end
    return acc;
  endfunction

  // Searches the powers of alpha for one whose product with x is one.
  function automatic logic find_reciprocal(input logic [RES_W-1:0] x,
                                           input logic [POLY_W-1:0] poly,
                                           output logic [RES_W-1:0] inv);
    logic [RES_W-1:0] pw;
    pw  = RES_W'(1);
    inv = '0;
    for (int n = 0; n < (1 << RES_W); n++) begin
      if (gf_product(pw, x, poly) == RES_W'(1)) begin
        inv = pw;
        return 1'b1;
      end
      pw = gf_product(pw, RES_W'(2), poly);
    end
    return 1'b0;
  endfunction

  function automatic gf_expect_t predict_gf_result(input logic [OP_W-1:0] op,
                                                   input logic [RES_W-1:0] a,
                                                   input logic [RES_W-1:0] b,
                                                   input logic [POLY_W-1:0] poly);
    gf_expect_t       r;
    logic [RES_W-1:0] inv;
    logic             found;
    r.op  = op;
    r.a   = a;
    r.b   = b;
    r.res = '0;
    r.err = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        r.res = a ^ b;
      end
      OP_MUL: begin
        r.res = gf_product(a, b, poly);
      end
      OP_DIV: begin
        found = find_reciprocal(b, poly, inv);
        if (found) begin
          r.res = gf_product(a, inv, poly);
        end else begin
          r.err = 1'b1;
        end
      end
      OP_INV: begin
        found = find_reciprocal(a, poly, inv);
        if (found) begin
          r.res = inv;
        end else begin
          r.err = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Track the polynomial, queue predictions on accepted requests and check
  // each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    gf_expect_t exp_r;
    if (!rst_ni) begin
      field_poly = POLY_RESET;
      expected_results.delete();
      fail_count_o    = 0;
      checked_count_o = 0;
      flagged_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        field_poly = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_gf_result(s_axis_tuser, s_axis_tdata[7:0],
                                                     s_axis_tdata[15:8], field_poly));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          if (fail_count_o < MAX_REPORTS) begin
            $display("checker: unexpected result %h error %b", m_axis_tdata, m_axis_tuser);
          end
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          checked_count_o++;
          if (m_axis_tuser) begin
            flagged_count_o++;
          end
          if (m_axis_tdata !== exp_r.res || m_axis_tuser !== exp_r.err) begin
            if (fail_count_o < MAX_REPORTS) begin
              $display("checker: op %0d a %h b %h poly %h: expected result %h error %b, got %h %b",
                       exp_r.op, exp_r.a, exp_r.b, field_poly, exp_r.res, exp_r.err,
                       m_axis_tdata, m_axis_tuser);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_count_o = expected_results.size();
  end

endmodule

// ===== test/galois_field_arithmetic_unit_top_tb.sv =====
// Testbench top for the GF(2^m) arithmetic unit: clock, reset, request and
// result traffic with random stalls, polynomial changes and the final verdict.
// Depends on gfau_pkg, galois_field_arithmetic_unit_top and gfau_result_checker.
module galois_field_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfau_pkg::*;

  localparam int unsigned   ITEMS_PER_SETTING = 210;
  localparam int unsigned   STALL_MAX         = 14;
  localparam int unsigned   WATCHDOG_LIMIT    = 3000;
  localparam int unsigned   SETTLE_CYCLES     = 300;
  localparam logic [OP_W-1:0] OP_UNDEF_LO     = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI     = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [POLY_W-1:0] cfg_wdata;
  logic              s_valid;
  logic              s_ready;
  logic [15:0]       s_data;
  logic [OP_W-1:0]   s_user;
  logic              m_valid;
  logic              m_ready;
  logic [RES_W-1:0]  m_data;
  logic              m_user;

  int fail_count;
  int pending_count;
  int checked_count;
  int flagged_count;
  int settings_count;
  bit tx_steady;
  bit rx_steady;

  galois_field_arithmetic_unit_top #(
    .FIELD_BITS(8)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  gfau_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid  (s_valid),
    .s_axis_tready  (s_ready),
    .s_axis_tdata   (s_data),
    .s_axis_tuser   (s_user),
    .m_axis_tvalid  (m_valid),
    .m_axis_tready  (m_ready),
    .m_axis_tdata   (m_data),
    .m_axis_tuser   (m_user),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .checked_count_o(checked_count),
    .flagged_count_o(flagged_count)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_count);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result, with steady stretches.
  initial begin
    int unsigned gap;
    m_ready <= 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        rx_steady = !rx_steady;
      end
      gap = rx_steady ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!(m_valid && m_ready));
    end
  end

  // Sends one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [RES_W-1:0] a,
                              input logic [RES_W-1:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      tx_steady = !tx_steady;
    end
    gap = tx_steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {b, a};
    do @(posedge clk); while (!(s_valid && s_ready));
  endtask

  // Field element biased toward zero, one and all ones.
  function automatic logic [RES_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return RES_W'(1);
      default: return RES_W'($urandom);
    endcase
  endfunction

  task automatic send_random_request();
    int unsigned      k;
    logic [OP_W-1:0]  op;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      op = OP_ADD;
    end else if (k < 24) begin
      op = OP_SUB;
    end else if (k < 50) begin
      op = OP_MUL;
    end else if (k < 72) begin
      op = OP_DIV;
    end else if (k < 94) begin
      op = OP_INV;
    end else begin
      op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    end
    send_request(op, pick_element(), pick_element());
  endtask

  // Stops sending and waits until every outstanding result has been checked.
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // Polynomial change while the unit is idle.
  task automatic write_polynomial(input logic [POLY_W-1:0] poly);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= poly;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_count++;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [POLY_W-1:0] polys[8];
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= '0;
    settings_count = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed requests under the reset polynomial.
    send_request(OP_ADD, 8'h00, 8'h00);
    send_request(OP_ADD, 8'hFF, 8'hFF);
    send_request(OP_ADD, 8'hA5, 8'h5A);
    send_request(OP_SUB, 8'hFF, 8'h00);
    send_request(OP_SUB, 8'h3C, 8'hC3);
    send_request(OP_MUL, 8'h00, 8'hFF);
    send_request(OP_MUL, 8'hFF, 8'h00);
    send_request(OP_MUL, 8'hFF, 8'hFF);
    send_request(OP_MUL, 8'h80, 8'h02);
    send_request(OP_MUL, 8'h01, 8'hB7);
    send_request(OP_MUL, 8'h53, 8'hCA);
    // Zero divisor and inverse of zero must flag an error.
    send_request(OP_DIV, 8'h00, 8'h00);
    send_request(OP_DIV, 8'h7F, 8'h00);
    send_request(OP_DIV, 8'h00, 8'h01);
    send_request(OP_DIV, 8'hFF, 8'hFF);
    send_request(OP_DIV, 8'h01, 8'h02);
    send_request(OP_DIV, 8'hC3, 8'h8E);
    send_request(OP_INV, 8'h00, 8'hFF);
    send_request(OP_INV, 8'h01, 8'h00);
    send_request(OP_INV, 8'h02, 8'h00);
    send_request(OP_INV, 8'hFF, 8'hAA);
    send_request(OP_INV, 8'h8E, 8'h00);
    // Undefined opcodes give a zero result without an error.
    send_request(OP_UNDEF_LO, 8'hFF, 8'hFF);
    send_request(OP_UNDEF_LO + 3'd1, 8'h12, 8'h34);
    send_request(OP_UNDEF_HI, 8'hFF, 8'hFF);

    // Random traffic under several polynomials, among them a non-primitive one,
    // both extremes, one without its top bit, a top bit alone and a random one.
    polys = '{9'h11B, 9'h000, 9'h1FF, 9'h0FF, 9'h12B, 9'h100,
              POLY_W'($urandom_range(0, 511)), POLY_RESET};
    foreach (polys[i]) begin
      write_polynomial(polys[i]);
      repeat (ITEMS_PER_SETTING) send_random_request();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results under %0d polynomial settings, %0d with the error flag.",
             checked_count, settings_count, flagged_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gfau_pkg.sv
hdl/gfau_step.sv
hdl/galois_field_arithmetic_unit_top.sv
test/gfau_result_checker.sv
test/galois_field_arithmetic_unit_top_tb.sv
